// File: design/psc_pkg.sv
package psc_pkg;

  localparam int RATE_W = 16;
  localparam int COUNT_W = 8;
  localparam int Q_W = 32;
  localparam int SEED_W = 32;

  // count range is cut to this many bits before the saturation compare
  localparam int COUNT_BITS = 8;
  localparam logic [COUNT_W-1:0] COUNT_MASK =
    (COUNT_BITS >= COUNT_W) ? {COUNT_W{1'b1}} : COUNT_W'((1 << COUNT_BITS) - 1);

  localparam logic [Q_W-1:0] ONE_Q32 = 32'hFFFF_FFFF;
  localparam logic [Q_W-1:0] EXP_NEG_ONE_Q32 = 32'd1580030169;
  localparam logic [Q_W-1:0] LFSR_TAPS = 32'hD000_0001;
  localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 8'd255;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  // taylor series for exp(-x): first term loaded directly, later terms 2..last
  localparam int TERM_W = 4;
  localparam logic [TERM_W-1:0] TERM_FIRST = 4'd2;
  localparam logic [TERM_W-1:0] TERM_LAST = 4'd14;

  // powers of exp(-1); every power past the table truncates to zero
  localparam int INT_ENTRIES = 32;
  localparam int INT_IDX_W = $clog2(INT_ENTRIES);
  typedef logic [INT_ENTRIES-1:0][Q_W-1:0] int_table_t;

  function automatic int_table_t build_int_table();
    int_table_t tbl;
    logic [2*Q_W-1:0] prod;
    logic [Q_W-1:0] v;
    v = ONE_Q32;
    tbl[0] = v;
    for (int i = 1; i < INT_ENTRIES; i++) begin
      prod = {{Q_W{1'b0}}, v} * {{Q_W{1'b0}}, EXP_NEG_ONE_Q32};
      v = prod[2*Q_W-1:Q_W];
      tbl[i] = v;
    end
    return tbl;
  endfunction

  localparam int_table_t INT_TABLE = build_int_table();

  // floor(2^32 / n) for the series divisors
  function automatic logic [Q_W-1:0] recip(input logic [TERM_W-1:0] n);
    logic [Q_W-1:0] r;
    unique case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      4'd13:   r = 32'd330382099;
      4'd14:   r = 32'd306783378;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [Q_W-1:0] lfsr_next(input logic [Q_W-1:0] w);
    logic [Q_W-1:0] s;
    s = w >> 1;
    if (w[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  typedef enum logic [0:0] {
    CFG_RNG_SEED,
    CFG_MAX_COUNT
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM_MUL,
    ST_TERM_DIV,
    ST_TERM_FIX,
    ST_THRESH,
    ST_SAMPLE,
    ST_CHECK
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TERM,
    MUL_DIV,
    MUL_THRESH,
    MUL_SAMPLE
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t op;
    logic    fix;
    logic    store;
  } cmd_t;

  typedef struct packed {
    logic series_end;
    logic hit;
    logic sat;
    logic out_free;
  } status_t;

endpackage

// File: design/psc_rate_if.sv
interface psc_rate_if;
  logic valid;
  logic ready;
  logic [psc_pkg::RATE_W-1:0] rate;

  modport source (output valid, output rate, input ready);
  modport sink (input valid, input rate, output ready);
endinterface

// File: design/psc_result_if.sv
interface psc_result_if;
  logic valid;
  logic ready;
  logic [psc_pkg::COUNT_W-1:0] count;
  logic clamped;

  modport source (output valid, output count, output clamped, input ready);
  modport sink (input valid, input count, input clamped, output ready);
endinterface

// File: design/psc_ctrl.sv
module psc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  psc_pkg::status_t  status,
  output psc_pkg::cmd_t     cmd
);

  psc_pkg::state_t state;
  psc_pkg::state_t state_next;
  logic done;

  assign done = status.hit || status.sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psc_pkg::ST_IDLE: begin
        if (in_valid) state_next = psc_pkg::ST_TERM_MUL;
      end
      psc_pkg::ST_TERM_MUL: state_next = psc_pkg::ST_TERM_DIV;
      psc_pkg::ST_TERM_DIV: state_next = psc_pkg::ST_TERM_FIX;
      psc_pkg::ST_TERM_FIX: begin
        state_next = status.series_end ? psc_pkg::ST_THRESH : psc_pkg::ST_TERM_MUL;
      end
      psc_pkg::ST_THRESH: state_next = psc_pkg::ST_SAMPLE;
      psc_pkg::ST_SAMPLE: state_next = psc_pkg::ST_CHECK;
      psc_pkg::ST_CHECK: begin
        priority if (done && status.out_free) begin
          state_next = psc_pkg::ST_IDLE;
        end else if (!done) begin
          state_next = psc_pkg::ST_SAMPLE;
        end
      end
      default: state_next = psc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.op    = psc_pkg::MUL_NONE;
    cmd.fix   = 1'b0;
    cmd.store = 1'b0;
    unique case (state)
      psc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      psc_pkg::ST_TERM_MUL: cmd.op = psc_pkg::MUL_TERM;
      psc_pkg::ST_TERM_DIV: cmd.op = psc_pkg::MUL_DIV;
      psc_pkg::ST_TERM_FIX: cmd.fix = 1'b1;
      psc_pkg::ST_THRESH:   cmd.op = psc_pkg::MUL_THRESH;
      psc_pkg::ST_SAMPLE:   cmd.op = psc_pkg::MUL_SAMPLE;
      psc_pkg::ST_CHECK:    cmd.store = done && status.out_free;
      default: ;
    endcase
  end

endmodule

// File: design/psc_datapath.sv
module psc_datapath #(
  parameter int RATE_FRAC_BITS = 12,
  parameter int UNIFORM_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [psc_pkg::RATE_W-1:0]    rate,
  input  logic                          cfg_we,
  input  psc_pkg::cfg_index_t           cfg_index,
  input  logic [psc_pkg::SEED_W-1:0]    cfg_data,
  input  psc_pkg::cmd_t                 cmd,
  output psc_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psc_pkg::COUNT_W-1:0]   count,
  output logic                          clamped
);

  localparam int QW = psc_pkg::Q_W;
  localparam int CW = psc_pkg::COUNT_W;
  localparam int TW = psc_pkg::TERM_W;

  // configuration
  logic [QW-1:0] lfsr;
  logic [CW-1:0] max_count;

  // series and sampling registers
  logic [QW-1:0] x;
  logic [QW-1:0] t;
  logic [QW:0]   sum;
  logic [TW-1:0] n;
  logic [QW-1:0] v;
  logic [QW-1:0] q;
  logic [QW-1:0] int_val;
  logic [QW-1:0] thresh;
  logic [QW-1:0] p;
  logic [CW-1:0] k;

  // combinational
  logic [psc_pkg::RATE_W:0] ipart;
  logic [psc_pkg::RATE_W+QW-1:0] rate_shift;
  logic [QW-1:0] x_in;
  logic [QW-1:0] int_in;
  logic [QW-1:0] lfsr_step;
  logic [QW-1:0] uni;
  logic [QW-1:0] frac;
  logic [QW-1:0] mul_a;
  logic [QW-1:0] mul_b;
  logic [2*QW-1:0] prod;
  logic [5:0] rem;
  logic [QW-1:0] t_fix;
  logic [QW:0] sum_fix;
  logic [CW-1:0] limit;

  // rate split: integer part picks a power of exp(-1), fraction feeds the series
  assign ipart      = (psc_pkg::RATE_W + 1)'(rate) >> RATE_FRAC_BITS;
  assign rate_shift = (psc_pkg::RATE_W + QW)'(rate) << (QW - RATE_FRAC_BITS);
  assign x_in       = rate_shift[QW-1:0];
  assign int_in     = (ipart < (psc_pkg::RATE_W + 1)'(psc_pkg::INT_ENTRIES))
                    ? psc_pkg::INT_TABLE[ipart[psc_pkg::INT_IDX_W-1:0]] : '0;

  assign lfsr_step = psc_pkg::lfsr_next(lfsr);
  assign uni       = lfsr_step >> (QW - UNIFORM_BITS);
  assign frac      = sum[QW] ? psc_pkg::ONE_Q32 : sum[QW-1:0];

  // the one shared multiplier
  always_comb begin
    unique case (cmd.op)
      psc_pkg::MUL_TERM:   begin mul_a = t;       mul_b = x; end
      psc_pkg::MUL_DIV:    begin mul_a = v;       mul_b = psc_pkg::recip(n); end
      psc_pkg::MUL_THRESH: begin mul_a = int_val; mul_b = frac; end
      psc_pkg::MUL_SAMPLE: begin mul_a = p;       mul_b = uni; end
      default:             begin mul_a = '0;      mul_b = '0; end
    endcase
  end

  assign prod = {{QW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};

  // quotient estimate is low by at most one, remainder fits six bits
  assign rem     = v[5:0] - 6'(q[5:0] * n);
  assign t_fix   = q + QW'(rem >= 6'(n));
  assign sum_fix = n[0] ? (sum - {1'b0, t_fix}) : (sum + {1'b0, t_fix});

  assign limit = max_count & psc_pkg::COUNT_MASK;

  assign status.series_end = (t_fix == '0) || (n == psc_pkg::TERM_LAST);
  assign status.hit        = (p <= thresh);
  assign status.sat        = (k >= limit);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr      <= psc_pkg::SEED_RESET;
      max_count <= psc_pkg::MAX_COUNT_RESET;
    end else begin
      priority if (cmd.op == psc_pkg::MUL_SAMPLE) begin
        lfsr <= lfsr_step;
      end else if (cfg_we) begin
        unique case (cfg_index)
          psc_pkg::CFG_RNG_SEED:  lfsr <= (cfg_data == '0) ? psc_pkg::SEED_RESET : cfg_data;
          psc_pkg::CFG_MAX_COUNT: max_count <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x       <= x_in;
      t       <= x_in;
      sum     <= {1'b1, {QW{1'b0}}} - {1'b0, x_in};
      n       <= psc_pkg::TERM_FIRST;
      int_val <= int_in;
      p       <= psc_pkg::ONE_Q32;
      k       <= '0;
    end
    if (cmd.fix) begin
      t   <= t_fix;
      sum <= sum_fix;
      n   <= n + TW'(1);
    end
    unique case (cmd.op)
      psc_pkg::MUL_TERM:   v <= prod[2*QW-1:QW];
      psc_pkg::MUL_DIV:    q <= prod[2*QW-1:QW];
      psc_pkg::MUL_THRESH: thresh <= prod[2*QW-1:QW];
      psc_pkg::MUL_SAMPLE: begin
        p <= prod[UNIFORM_BITS +: QW];
        k <= k + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      count   <= status.hit ? (k - CW'(1)) : limit;
      clamped <= !status.hit;
    end
  end

endmodule

// File: design/poisson_count_sampler_unit.sv
// poisson count sampler: one beat in (rate lambda, unsigned q4.12) gives one
// beat out (a poisson count and a clamp flag) by knuth's product method.
// exp(-lambda) is the product of a power of exp(-1) from a small constant
// table and a taylor series for the fraction, evaluated in q0.32. a running
// product starting at 1.0 is multiplied by 32-bit galois lfsr uniforms until
// it drops to the threshold or the count reaches max_count. one item at a
// time; the work per item grows with the count and with the number of
// series terms worked (at most 13, fewer once a term truncates to zero).
// the shape comes from sharing one 32x32 multiplier: each series term takes
// a product, a reciprocal divide and a fix-up step, each sample step a
// multiply and a compare, and the threshold one more multiply. a finished
// result waits in the compare step while the output register is still full.
// the next rate beat is taken as soon as the result is in the output register.
// writing rng_seed loads the lfsr at once (zero loads 1); configure only
// while idle.
module poisson_count_sampler_unit #(
  parameter int RATE_FRAC_BITS = 12,
  parameter int UNIFORM_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  psc_rate_if.sink                    rate_in,
  psc_result_if.source                result_out,
  input  logic                        cfg_we,
  input  psc_pkg::cfg_index_t         cfg_index,
  input  logic [psc_pkg::SEED_W-1:0]  cfg_data
);

  // command and status between sequencer and datapath
  psc_pkg::cmd_t    cmd;
  psc_pkg::status_t status;

  // sequencer: series terms, threshold, sample loop, result hand-off
  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rate_in.valid),
    .in_ready (rate_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: shared multiplier, lfsr, config registers, output register
  psc_datapath #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS),
    .UNIFORM_BITS   (UNIFORM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rate      (rate_in.rate),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .count     (result_out.count),
    .clamped   (result_out.clamped)
  );

endmodule

// File: tb/poisson_count_sampler_unit_tb.sv
module poisson_count_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // run length guards
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int END_WAIT = 600;     // end settle time, longer than the worst item
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off, several items deep
  localparam int PHASE_ITEMS = 86;
  localparam int REPORT_MAX = 10;

  // fixed-point constants of the sampler
  localparam logic [31:0] Q_ONE = 32'hFFFF_FFFF;
  localparam logic [31:0] INV_E_Q32 = 32'd1580030169;
  localparam logic [31:0] GEN_TAPS = 32'hD000_0001;

  typedef struct packed {
    logic [7:0] count;
    logic       clamped;
  } count_beat_t;

  // a known result typed into the directed table, or none
  typedef struct {
    bit          fixed;
    count_beat_t value;
  } known_t;

  // one row of the directed table: a register write or a rate beat
  typedef struct {
    bit                   is_write;
    psc_pkg::cfg_index_t  reg_sel;
    logic [31:0]          wdata;
    logic [15:0]          rate;
    bit                   fixed;
    logic [7:0]           count;
    logic                 clamped;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  psc_pkg::cfg_index_t cfg_index;
  logic [psc_pkg::SEED_W-1:0] cfg_data;

  psc_rate_if rate_if();
  psc_result_if result_if();

  poisson_count_sampler_unit uut (
    .clk(clk),
    .rst(rst),
    .rate_in(rate_if),
    .result_out(result_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state, starts at the reset values
  logic [31:0] gen_word = 32'd1;
  logic [7:0] sat_limit = 8'd255;

  // expected counts in beat order, plus typed-in values riding with the rates
  count_beat_t pending_counts[$];
  known_t typed_counts[$];

  int rates_sent = 0;
  int counts_seen = 0;
  int clamps_seen = 0;
  int mismatches = 0;
  int settings_used = 0;
  logic [7:0] top_count = 8'd0;
  int unsigned cycle_count = 0;

  // idling knobs, percent chance of a burst per beat or cycle
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;

  // truncated q0.32 product
  function automatic logic [31:0] q32_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] wide;
    wide = {32'd0, a} * {32'd0, b};
    return wide[63:32];
  endfunction

  // exp(-n) as repeated truncated powers of exp(-1)
  function automatic logic [31:0] exp_whole(input logic [3:0] n);
    logic [31:0] v;
    v = Q_ONE;
    for (int i = 0; i < n; i++) v = q32_mul(v, INV_E_Q32);
    return v;
  endfunction

  // exp(-f) for the fraction by an alternating series up to the x^14 term
  function automatic logic [31:0] exp_frac(input logic [11:0] f);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] acc;
    x = {32'd0, f, 20'd0};
    term = 64'h1_0000_0000;
    acc = term;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return (acc > {32'd0, Q_ONE}) ? Q_ONE : acc[31:0];
  endfunction

  // knuth's product loop on the q4.12 rate; advances the generator
  function automatic count_beat_t draw_poisson(input logic [15:0] r);
    count_beat_t res;
    logic [31:0] thresh;
    logic [31:0] prod;
    int k;
    bit done;
    thresh = q32_mul(exp_whole(r[15:12]), exp_frac(r[11:0]));
    prod = Q_ONE;
    k = 0;
    done = 1'b0;
    res = '0;
    do begin
      if (gen_word[0]) gen_word = (gen_word >> 1) ^ GEN_TAPS;
      else gen_word = gen_word >> 1;
      prod = q32_mul(prod, gen_word);
      k++;
      if (prod <= thresh) begin
        res.count = 8'(k - 1);
        done = 1'b1;
      end else if (k >= int'(sat_limit)) begin
        // saturation, also covers a limit of zero
        res.count = sat_limit;
        res.clamped = 1'b1;
        done = 1'b1;
      end
    end while (!done);
    return res;
  endfunction

  function automatic step_row_t rate_row(input logic [15:0] r, input bit fixed,
                                         input logic [7:0] c, input logic cl);
    step_row_t row;
    row.is_write = 1'b0;
    row.reg_sel = psc_pkg::CFG_RNG_SEED;
    row.wdata = '0;
    row.rate = r;
    row.fixed = fixed;
    row.count = c;
    row.clamped = cl;
    return row;
  endfunction

  function automatic step_row_t reg_row(input psc_pkg::cfg_index_t sel,
                                        input logic [31:0] d);
    step_row_t row;
    row = rate_row(16'd0, 1'b0, 8'd0, 1'b0);
    row.is_write = 1'b1;
    row.reg_sel = sel;
    row.wdata = d;
    return row;
  endfunction

  // mostly full-range rates, some small lambda, some integer corners
  function automatic logic [15:0] pick_rate();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom());
    if (sel < 9) return 16'($urandom_range(0, 16'h1FFF));
    return {4'($urandom_range(0, 15)), ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000};
  endfunction

  // offer one rate beat, maybe after an idle burst, and wait for acceptance
  task automatic send_rate(input logic [15:0] r, input bit fixed, input count_beat_t want);
    known_t tag;
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      rate_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.fixed = fixed;
    tag.value = want;
    typed_counts.push_back(tag);
    // valid stays high into the next beat when there is no gap
    rate_if.valid <= 1'b1;
    rate_if.rate <= r;
    do @(posedge clk); while (!rate_if.ready);
    rates_sent++;
  endtask

  // stop offering and wait for every outstanding count, then settle
  task automatic drain();
    rate_if.valid <= 1'b0;
    while (counts_seen != rates_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write only once the unit is idle
  task automatic write_reg(input psc_pkg::cfg_index_t sel, input logic [31:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    // zero seed loads 1 so the generator never locks
    if (sel == psc_pkg::CFG_RNG_SEED) gen_word = (d != 32'd0) ? d : 32'd1;
    else sat_limit = d[7:0];
    settings_used++;
  endtask

  // rate monitor: predict at each accepted beat
  always @(posedge clk) begin
    known_t tag;
    count_beat_t guess;
    if (!rst && rate_if.valid && rate_if.ready) begin
      guess = draw_poisson(rate_if.rate);
      tag = typed_counts.pop_front();
      pending_counts.push_back(tag.fixed ? tag.value : guess);
    end
  end

  // result checker: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    count_beat_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      counts_seen++;
      if (result_if.clamped) clamps_seen++;
      if (result_if.count > top_count) top_count = result_if.count;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected result beat: count=%0d clamped=%0d",
                   $realtime, result_if.count, result_if.clamped);
      end else begin
        want = pending_counts.pop_front();
        if (want.count !== result_if.count || want.clamped !== result_if.clamped) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] result beat %0d: expected count=%0d clamped=%0d, got count=%0d clamped=%0d",
                     $realtime, counts_seen, want.count, want.clamped,
                     result_if.count, result_if.clamped);
        end
      end
    end
  end

  // receiver: random stall bursts, and one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rst) begin
        result_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        // output backs up, the unit must stall its rate input
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 11);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d counts seen",
               cycle_count, counts_seen, rates_sent);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    step_row_t rows[$];
    logic [7:0] limit;
    rate_if.valid <= 1'b0;
    rate_if.rate <= '0;
    cfg_we <= 1'b0;
    cfg_index <= psc_pkg::CFG_RNG_SEED;
    cfg_data <= '0;

    // directed table; counts typed in only where they follow at a glance
    // reset settings: seed 1, limit 255; rate zero always stops on the first step
    rows.push_back(rate_row(16'h0000, 1'b1, 8'd0, 1'b0));
    rows.push_back(rate_row(16'hFFFF, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h1000, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h0FFF, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'hF000, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h0001, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h8000, 1'b0, 8'd0, 1'b0));
    // zero seed loads 1, zero limit: a large rate clamps at zero at once
    rows.push_back(reg_row(psc_pkg::CFG_RNG_SEED, 32'd0));
    rows.push_back(reg_row(psc_pkg::CFG_MAX_COUNT, 32'd0));
    rows.push_back(rate_row(16'h0000, 1'b1, 8'd0, 1'b0));
    rows.push_back(rate_row(16'hFFFF, 1'b1, 8'd0, 1'b1));
    rows.push_back(rate_row(16'h4000, 1'b0, 8'd0, 1'b0));
    // seed 1, limit 1: first uniform is far above the threshold, clamps at one
    rows.push_back(reg_row(psc_pkg::CFG_RNG_SEED, 32'd1));
    rows.push_back(reg_row(psc_pkg::CFG_MAX_COUNT, 32'd1));
    rows.push_back(rate_row(16'hFFFF, 1'b1, 8'd1, 1'b1));
    rows.push_back(rate_row(16'h0000, 1'b1, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h2800, 1'b0, 8'd0, 1'b0));
    // all-ones seed, full limit
    rows.push_back(reg_row(psc_pkg::CFG_RNG_SEED, 32'hFFFF_FFFF));
    rows.push_back(reg_row(psc_pkg::CFG_MAX_COUNT, 32'd255));
    rows.push_back(rate_row(16'hFFFF, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'hA5A5, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h5A5A, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h0800, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'hF800, 1'b0, 8'd0, 1'b0));
    // small limit, large rates mostly saturate
    rows.push_back(reg_row(psc_pkg::CFG_MAX_COUNT, 32'd3));
    rows.push_back(rate_row(16'hC000, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h3000, 1'b0, 8'd0, 1'b0));
    rows.push_back(rate_row(16'h0000, 1'b1, 8'd0, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 15;
    stall_pct = 15;
    foreach (rows[i]) begin
      if (rows[i].is_write)
        write_reg(rows[i].reg_sel, rows[i].wdata);
      else
        send_rate(rows[i].rate, rows[i].fixed, {rows[i].count, rows[i].clamped});
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: begin limit = 8'd255; gap_pct = 20; stall_pct = 20; end
        1: begin limit = 8'd1; gap_pct = 0; stall_pct = 30; end
        2: begin limit = 8'($urandom_range(2, 20)); gap_pct = 30; stall_pct = 0; end
        3: begin limit = 8'($urandom_range(21, 254)); gap_pct = 10; stall_pct = 10; end
        default: begin limit = 8'd255; gap_pct = 0; stall_pct = 0; end  // no idling at the end
      endcase
      write_reg(psc_pkg::CFG_RNG_SEED, $urandom());
      // upper data bits are junk, only the low byte counts
      write_reg(psc_pkg::CFG_MAX_COUNT, {24'($urandom()), limit});
      // long hold-off while the sender keeps offering back to back
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender pause midway until everything is back
        if (ph == 2 && i == PHASE_ITEMS / 2) drain();
        send_rate(pick_rate(), 1'b0, '0);
      end
    end

    rate_if.valid <= 1'b0;
    while (counts_seen != rates_sent) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $display("%0d expected counts never arrived", pending_counts.size());
      mismatches += pending_counts.size();
    end

    $display("run covered %0d rate beats under %0d register writes", rates_sent, settings_used);
    $display("%0d counts came back clamped, largest count %0d", clamps_seen, top_count);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
